>>> sv/tps_pkg.sv
// shared constants, codes and types for the topological sort block
`default_nettype none
package tps_pkg;

  // storage sizes
  localparam int MAX_NODES = 32;
  localparam int MAX_EDGES = 256;

  // node indices and emitted results are limited by the 5-bit node field
  localparam int RESULT_LIMIT = 32;
  localparam int N_LIMIT      = (MAX_NODES < RESULT_LIMIT) ? MAX_NODES : RESULT_LIMIT;

  // widths
  localparam int NODE_W     = 5;                        // node index field
  localparam int CNT_W      = 6;                        // node count register
  localparam int EDGE_AW    = $clog2(MAX_EDGES);        // edge store address
  localparam int EDGE_CW    = $clog2(MAX_EDGES + 1);    // edge total, holds full count
  localparam int DEG_W      = $clog2(MAX_EDGES + 1);    // per-node in-degree
  localparam int EDGE_REC_W = 2 * NODE_W;               // {from, to} record

  // command codes
  localparam logic CMD_ADD_EDGE = 1'b0;
  localparam logic CMD_SORT     = 1'b1;

  // engine status toward the top level
  typedef struct packed {
    logic busy;
    logic done;
  } tps_status_t;

endpackage
`default_nettype wire

>>> sv/tps_ram.sv
// generic single-clock ram, one write port and one registered read port
`default_nettype none
module tps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

>>> sv/tps_engine.sv
// kahn sort sequencer: in-degree counters, order queue, edge sweeps and emit
`default_nettype none
module tps_engine (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          sort_go,
  input  wire logic [tps_pkg::CNT_W-1:0]     node_count,
  input  wire logic [tps_pkg::EDGE_CW-1:0]   edge_total,
  input  wire logic                          overflow,
  output logic      [tps_pkg::EDGE_AW-1:0]   rd_addr,
  input  wire logic [tps_pkg::EDGE_REC_W-1:0] rd_data,
  output tps_pkg::tps_status_t               status,
  output logic                               out_valid,
  output logic      [tps_pkg::NODE_W-1:0]    out_node_index,
  output logic                               out_cycle_found,
  output logic                               out_edges_dropped,
  output logic                               out_last
);
  import tps_pkg::*;

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_COUNT = 3'd1;
  localparam logic [2:0] ST_SEED  = 3'd2;
  localparam logic [2:0] ST_POP   = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [EDGE_CW-1:0] e_r, e_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [CNT_W-1:0]   i_r, i_nxt;
  logic [CNT_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]   tail_r, tail_nxt;
  logic [NODE_W-1:0]  node_r, node_nxt;
  logic               cycle_r, cycle_nxt;
  logic [DEG_W-1:0]   indeg_r [MAX_NODES];
  logic [DEG_W-1:0]   indeg_nxt [MAX_NODES];
  logic [NODE_W-1:0]  queue_r [MAX_NODES];
  logic [NODE_W-1:0]  queue_nxt [MAX_NODES];

  logic               out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0]  out_node_r, out_node_nxt;
  logic               out_cycle_r, out_cycle_nxt;
  logic               out_drop_r, out_drop_nxt;
  logic               out_last_r, out_last_nxt;

  logic [NODE_W-1:0]  rd_src;
  logic [NODE_W-1:0]  rd_dst;
  logic               src_ok;
  logic               dst_ok;
  logic [DEG_W-1:0]   dec_deg;
  logic               issue;
  logic               sweep_done;
  logic [CNT_W-1:0]   n_eff;
  logic [CNT_W:0]     i_inc;
  logic               emit_end;

  // edge record fields and range checks
  assign rd_src  = rd_data[EDGE_REC_W-1:NODE_W];
  assign rd_dst  = rd_data[NODE_W-1:0];
  assign src_ok  = {1'b0, rd_src} < n_r;
  assign dst_ok  = {1'b0, rd_dst} < n_r;
  assign dec_deg = indeg_r[rd_dst] - DEG_W'(1);

  // edge sweep: one read issued per cycle, data in the cycle after
  assign issue      = e_r < edge_total;
  assign sweep_done = !issue && !rd_vld_r;
  assign rd_addr    = e_r[EDGE_AW-1:0];

  // node count clamped to the supported range
  assign n_eff = (node_count > CNT_W'(N_LIMIT)) ? CNT_W'(N_LIMIT) : node_count;

  // emit bookkeeping
  assign i_inc    = {1'b0, i_r} + (CNT_W+1)'(1);
  assign emit_end = i_inc >= {1'b0, n_r};

  // sequencer next state
  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    e_nxt         = e_r;
    rd_vld_nxt    = 1'b0;
    i_nxt         = i_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    node_nxt      = node_r;
    cycle_nxt     = cycle_r;
    indeg_nxt     = indeg_r;
    queue_nxt     = queue_r;
    out_valid_nxt = 1'b0;
    out_node_nxt  = out_node_r;
    out_cycle_nxt = out_cycle_r;
    out_drop_nxt  = out_drop_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (sort_go) begin
          n_nxt    = n_eff;
          e_nxt    = '0;
          head_nxt = '0;
          tail_nxt = '0;
          for (int k = 0; k < MAX_NODES; k++) begin
            indeg_nxt[k] = '0;
          end
          state_nxt = ST_COUNT;
        end
      end
      ST_COUNT: begin
        if (issue) begin
          e_nxt      = e_r + EDGE_CW'(1);
          rd_vld_nxt = 1'b1;
        end
        if (rd_vld_r && src_ok && dst_ok) begin
          indeg_nxt[rd_dst] = indeg_r[rd_dst] + DEG_W'(1);
        end
        if (sweep_done) begin
          i_nxt     = '0;
          state_nxt = ST_SEED;
        end
      end
      ST_SEED: begin
        // zero in-degree nodes join the queue in index order
        if (i_r < n_r) begin
          if (indeg_r[i_r[NODE_W-1:0]] == '0) begin
            queue_nxt[tail_r[NODE_W-1:0]] = i_r[NODE_W-1:0];
            tail_nxt = tail_r + CNT_W'(1);
          end
          i_nxt = i_r + CNT_W'(1);
        end else begin
          state_nxt = ST_POP;
        end
      end
      ST_POP: begin
        if (head_r < tail_r) begin
          node_nxt  = queue_r[head_r[NODE_W-1:0]];
          head_nxt  = head_r + CNT_W'(1);
          e_nxt     = '0;
          state_nxt = ST_SCAN;
        end else begin
          cycle_nxt = tail_r != n_r;
          i_nxt     = '0;
          state_nxt = ST_EMIT;
        end
      end
      ST_SCAN: begin
        // release successors of the popped node in edge arrival order
        if (issue) begin
          e_nxt      = e_r + EDGE_CW'(1);
          rd_vld_nxt = 1'b1;
        end
        if (rd_vld_r && rd_src == node_r && dst_ok) begin
          indeg_nxt[rd_dst] = dec_deg;
          if (dec_deg == '0 && tail_r < n_r) begin
            queue_nxt[tail_r[NODE_W-1:0]] = rd_dst;
            tail_nxt = tail_r + CNT_W'(1);
          end
        end
        if (sweep_done) begin
          state_nxt = ST_POP;
        end
      end
      ST_EMIT: begin
        if (i_r < n_r) begin
          out_valid_nxt = 1'b1;
          out_node_nxt  = cycle_r ? i_r[NODE_W-1:0] : queue_r[i_r[NODE_W-1:0]];
          out_cycle_nxt = cycle_r;
          out_drop_nxt  = overflow;
          out_last_nxt  = i_inc == {1'b0, n_r};
          i_nxt         = i_r + CNT_W'(1);
        end
        if (emit_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    e_r         <= e_nxt;
    i_r         <= i_nxt;
    head_r      <= head_nxt;
    tail_r      <= tail_nxt;
    node_r      <= node_nxt;
    cycle_r     <= cycle_nxt;
    indeg_r     <= indeg_nxt;
    queue_r     <= queue_nxt;
    out_node_r  <= out_node_nxt;
    out_cycle_r <= out_cycle_nxt;
    out_drop_r  <= out_drop_nxt;
    out_last_r  <= out_last_nxt;
  end

  // status and result beat
  assign status.busy       = state_r != ST_IDLE;
  assign status.done       = state_r == ST_EMIT && emit_end;
  assign out_valid         = out_valid_r;
  assign out_node_index    = out_node_r;
  assign out_cycle_found   = out_cycle_r;
  assign out_edges_dropped = out_drop_r;
  assign out_last          = out_last_r;

  // a result beat only follows an emit cycle
  a_beat_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r) == ST_EMIT)
    else $error("result beat outside emit phase");

  // queue never holds more entries than nodes
  a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEED || state_r == ST_POP || state_r == ST_SCAN) |-> tail_r <= n_r)
    else $error("order queue overrun");

  // dequeue never passes enqueue
  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP || state_r == ST_SCAN) |-> head_r <= tail_r)
    else $error("queue head passed tail");

  // completion returns the sequencer to idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    status.done |=> state_r == ST_IDLE)
    else $error("sort did not finish");

endmodule
`default_nettype wire

>>> sv/dependency_topological_sort.sv
// Topological sort of up to 32 nodes over up to 256 precedence edges (FIFO Kahn order).
// An add-edge command is taken while idle and busy stays low. A sort command holds
// busy high while the single read port of the edge store is swept once to count
// in-degrees and once more for every node taken off the queue. The result beats, one
// per node, come one per cycle at the end of the sort, out_valid high for one cycle
// each, the last beat in the first cycle with busy low again; the receiver cannot stall
// them. A cycle in the graph gives the identity order with cycle_found set. The edge
// store and the dropped-edge flag are cleared as each sort completes; the user must
// change node_count only while idle, as the block itself does not enforce it.
`default_nettype none
module dependency_topological_sort (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [tps_pkg::CNT_W-1:0]  cfg_node_count,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       in_command,
  input  wire logic [tps_pkg::NODE_W-1:0] in_edge_from,
  input  wire logic [tps_pkg::NODE_W-1:0] in_edge_to,
  output logic                            out_valid,
  output logic      [tps_pkg::NODE_W-1:0] out_node_index,
  output logic                            out_cycle_found,
  output logic                            out_edges_dropped,
  output logic                            out_last
);
  import tps_pkg::*;

  logic [CNT_W-1:0]      node_count_r;
  logic [EDGE_CW-1:0]    edge_total_r, edge_total_nxt;
  logic                  overflow_r, overflow_nxt;
  logic                  accept;
  logic                  add_edge;
  logic                  store_full;
  logic                  edge_we;
  logic [EDGE_AW-1:0]    rd_addr;
  logic [EDGE_REC_W-1:0] rd_data;
  tps_status_t           status;

  // command decode
  assign accept     = start && !status.busy;
  assign add_edge   = accept && in_command == CMD_ADD_EDGE;
  assign store_full = edge_total_r == EDGE_CW'(MAX_EDGES);
  assign edge_we    = add_edge && !store_full;
  assign busy       = status.busy;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= '0;
    end else if (cfg_we) begin
      node_count_r <= cfg_node_count;
    end
  end

  // edge fill count and overflow flag, emptied when a sort completes
  always_comb begin
    edge_total_nxt = edge_total_r;
    overflow_nxt   = overflow_r;
    priority if (status.done) begin
      edge_total_nxt = '0;
      overflow_nxt   = 1'b0;
    end else if (edge_we) begin
      edge_total_nxt = edge_total_r + EDGE_CW'(1);
    end else if (add_edge) begin
      overflow_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_total_r <= '0;
      overflow_r   <= 1'b0;
    end else begin
      edge_total_r <= edge_total_nxt;
      overflow_r   <= overflow_nxt;
    end
  end

  // edge store, records kept in arrival order
  tps_ram #(
    .WIDTH (EDGE_REC_W),
    .DEPTH (MAX_EDGES)
  ) u_edge_store (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_total_r[EDGE_AW-1:0]),
    .wdata ({in_edge_from, in_edge_to}),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // sort sequencer
  tps_engine u_engine (
    .clk               (clk),
    .rst_n             (rst_n),
    .sort_go           (accept && in_command == CMD_SORT),
    .node_count        (node_count_r),
    .edge_total        (edge_total_r),
    .overflow          (overflow_r),
    .rd_addr           (rd_addr),
    .rd_data           (rd_data),
    .status            (status),
    .out_valid         (out_valid),
    .out_node_index    (out_node_index),
    .out_cycle_found   (out_cycle_found),
    .out_edges_dropped (out_edges_dropped),
    .out_last          (out_last)
  );

  // overflow only raised by an edge that met a full store
  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(overflow_r) |-> edge_total_r == EDGE_CW'(MAX_EDGES))
    else $error("overflow set with room in edge store");

endmodule
`default_nettype wire
